FILE: src/tbq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tbq_pkg;

  // axes carried by one sample transaction
  localparam int NUM_AXES = 3;

  // schedule counter
  localparam int CNT_W = 4;

  // multiplier issue slots of the per-lane schedule
  localparam logic [CNT_W-1:0] STEP_GAIN = 4'd0;
  localparam logic [CNT_W-1:0] STEP_B1   = 4'd1;
  localparam logic [CNT_W-1:0] STEP_B2   = 4'd2;
  localparam logic [CNT_W-1:0] STEP_A1H  = 4'd3;
  localparam logic [CNT_W-1:0] STEP_A1L  = 4'd4;
  localparam logic [CNT_W-1:0] STEP_A2H  = 4'd5;
  localparam logic [CNT_W-1:0] STEP_A2L  = 4'd6;
  localparam logic [CNT_W-1:0] STEP_B0   = 4'd7;
  // state update once the biquad sum is complete, then the output scale products
  localparam logic [CNT_W-1:0] STEP_UPD  = 4'd10;
  localparam logic [CNT_W-1:0] STEP_SH   = 4'd11;
  localparam logic [CNT_W-1:0] STEP_SL   = 4'd12;
  // result saturation, last cycle of the schedule
  localparam logic [CNT_W-1:0] STEP_LAST = 4'd14;

  // configuration register indexes
  localparam int CFG_IDX_W = 4;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0    = 4'd0,
    REG_B1    = 4'd1,
    REG_B2    = 4'd2,
    REG_A1    = 4'd3,
    REG_A2    = 4'd4,
    REG_SCALE = 4'd5,
    REG_GAIN  = 4'd6,
    REG_REMAP = 4'd7
  } cfg_reg_t;

  // sequencer to lane control
  typedef struct packed {
    logic             run;
    logic [CNT_W-1:0] cnt;
  } ctl_t;

  // filter coefficients shared by all lanes
  typedef struct packed {
    logic [31:0] b0;
    logic [31:0] b1;
    logic [31:0] b2;
    logic [31:0] a1;
    logic [31:0] a2;
    logic [31:0] scale;
    logic [31:0] gain;
  } coef_t;

endpackage

`default_nettype wire

FILE: src/triaxial_biquad_lowpass.sv
`timescale 1ns / 1ps
`default_nettype none

// Three-axis biquad low-pass filter for Q16.16 sensor samples. Each accepted
// transaction is optionally remapped (x and y swapped, z negated), scaled by
// the input gain and run through one direct-form-1 biquad per axis, with the
// feedback terms added; the unscaled output is kept as filter state and the
// result is that output times the scale coefficient, saturated to 32 bits.
// Axes run in parallel lanes, each with one 33x32 multiplier that is stepped
// through ten products; the lane result is registered at the end of the
// schedule and then moves into the output register once it is free. The input
// stalls until then, so a new sample is taken only after the last one has left
// the lanes. A new sample is taken while a result still waits on out_stall; it
// finishes only when the output register frees. The user writes coefficients
// through the cfg port only while the filter is idle; the block does not
// enforce this. cfg_ready is always high and unknown indexes are ignored.
module triaxial_biquad_lowpass #(
  parameter int LANES = 3
) (
  input  wire                clk,
  input  wire                rst_n,
  // sample channel
  input  wire                in_valid,
  output logic               in_stall,
  input  wire signed [31:0]  in_sample_x,
  input  wire signed [31:0]  in_sample_y,
  input  wire signed [31:0]  in_sample_z,
  // result channel
  output logic               out_valid,
  input  wire                out_stall,
  output logic signed [31:0] out_filt_x,
  output logic signed [31:0] out_filt_y,
  output logic signed [31:0] out_filt_z,
  // configuration channel
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire [tbq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [31:0]         cfg_data
);

  localparam int NL = (LANES < tbq_pkg::NUM_AXES) ? LANES : tbq_pkg::NUM_AXES;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_BUSY = 3'b010,
    S_HOLD = 3'b100
  } state_t;

  state_t                      state_r, state_nxt;
  logic [tbq_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  tbq_pkg::coef_t              coef_r;
  logic                        remap_r;
  tbq_pkg::ctl_t               ctl;
  logic signed [31:0]          ax_r [tbq_pkg::NUM_AXES];
  logic signed [31:0]          neg_z;
  logic signed [31:0]          lane_res [NL];
  logic                        in_accept;
  logic                        cfg_write;
  logic                        merge_free;
  logic                        merge_load;

  assign in_stall   = (state_r != S_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign cfg_ready  = 1'b1;
  assign cfg_write  = cfg_valid && cfg_ready;
  assign merge_load = (state_r == S_HOLD) && merge_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.b0    <= 32'd536870912;
      coef_r.b1    <= 32'd1073741824;
      coef_r.b2    <= 32'd536870912;
      coef_r.a1    <= 32'd1026066111;
      coef_r.a2    <= 32'hE2B8_8498;
      coef_r.scale <= 32'd507178;
      coef_r.gain  <= 32'd16777216;
      remap_r      <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        tbq_pkg::REG_B0:    coef_r.b0    <= cfg_data;
        tbq_pkg::REG_B1:    coef_r.b1    <= cfg_data;
        tbq_pkg::REG_B2:    coef_r.b2    <= cfg_data;
        tbq_pkg::REG_A1:    coef_r.a1    <= cfg_data;
        tbq_pkg::REG_A2:    coef_r.a2    <= cfg_data;
        tbq_pkg::REG_SCALE: coef_r.scale <= cfg_data;
        tbq_pkg::REG_GAIN:  coef_r.gain  <= cfg_data;
        tbq_pkg::REG_REMAP: remap_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // axis remap, negation of z saturates at the most negative value
  assign neg_z = (in_sample_z == 32'sh80000000) ? 32'sh7FFFFFFF : -in_sample_z;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      if (remap_r) begin
        ax_r[0] <= in_sample_y;
        ax_r[1] <= in_sample_x;
        ax_r[2] <= neg_z;
      end else begin
        ax_r[0] <= in_sample_x;
        ax_r[1] <= in_sample_y;
        ax_r[2] <= in_sample_z;
      end
    end
  end

  // schedule sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = S_BUSY;
          cnt_nxt   = '0;
        end
      end
      S_BUSY: begin
        if (cnt_r == tbq_pkg::STEP_LAST) begin
          state_nxt = S_HOLD;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_HOLD: begin
        if (merge_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign ctl.run = (state_r == S_BUSY);
  assign ctl.cnt = cnt_r;

  // one filter lane for each of the first NL axes
  for (genvar i = 0; i < NL; i++) begin : g_lane
    tbq_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .coef  (coef_r),
      .ax    (ax_r[i]),
      .res   (lane_res[i])
    );
  end

  // result collection and output register
  tbq_merge #(
    .NL (NL)
  ) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (merge_load),
    .lane_res   (lane_res),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_filt_x (out_filt_x),
    .out_filt_y (out_filt_y),
    .out_filt_z (out_filt_z),
    .free       (merge_free)
  );

`ifndef SYNTHESIS
  // an accepted sample starts the schedule at its first slot
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == S_BUSY) && (cnt_r == '0))
    else $error("schedule did not start after sample accept");

  // the counter never runs past the last slot
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BUSY) |-> (cnt_r <= tbq_pkg::STEP_LAST))
    else $error("schedule counter out of range");

  // a result waits while the output register is occupied and stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_HOLD) && !merge_free) |=> (state_r == S_HOLD))
    else $error("result dropped while output stalled");

  // a new result appears only after a finished schedule
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_HOLD))
    else $error("output valid without a finished sample");
`endif

endmodule

`default_nettype wire

FILE: src/tbq_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module tbq_lane (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire tbq_pkg::ctl_t   ctl,
  input  wire tbq_pkg::coef_t  coef,
  input  wire signed [31:0]    ax,
  output logic signed [31:0]   res
);

  function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
    logic signed [31:0] r;
    if (v > 52'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -52'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [55:0] v);
    logic signed [47:0] r;
    if (v > 56'sh0000_7FFF_FFFF_FFFF) r = 48'sh7FFF_FFFF_FFFF;
    else if (v < -56'sh0000_8000_0000_0000) r = 48'sh8000_0000_0000;
    else r = v[47:0];
    return r;
  endfunction

  // shared multiplier operands and registered product
  logic signed [32:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [64:0] prod_r;

  // filter state
  logic signed [31:0] x1_r, x2_r;
  logic signed [47:0] y1_r, y2_r;

  // per-sample working registers
  logic signed [31:0] x0_r;
  logic signed [55:0] hold_r;
  logic signed [51:0] term_r;
  logic signed [55:0] acc_r;
  logic signed [31:0] res_r;

  logic signed [40:0] gain_sh;
  logic signed [51:0] gain_ext;
  logic signed [51:0] b_term;
  logic signed [80:0] full_sum;
  logic signed [51:0] l_term;
  logic signed [47:0] y0_sat;

  // operand select for the current schedule slot
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctl.cnt)
      tbq_pkg::STEP_GAIN: begin
        mul_a = {ax[31], ax};
        mul_b = $signed(coef.gain);
      end
      tbq_pkg::STEP_B1: begin
        mul_a = {x1_r[31], x1_r};
        mul_b = $signed(coef.b1);
      end
      tbq_pkg::STEP_B2: begin
        mul_a = {x2_r[31], x2_r};
        mul_b = $signed(coef.b2);
      end
      tbq_pkg::STEP_A1H: begin
        mul_a = {{9{y1_r[47]}}, y1_r[47:24]};
        mul_b = $signed(coef.a1);
      end
      tbq_pkg::STEP_A1L: begin
        mul_a = {9'd0, y1_r[23:0]};
        mul_b = $signed(coef.a1);
      end
      tbq_pkg::STEP_A2H: begin
        mul_a = {{9{y2_r[47]}}, y2_r[47:24]};
        mul_b = $signed(coef.a2);
      end
      tbq_pkg::STEP_A2L: begin
        mul_a = {9'd0, y2_r[23:0]};
        mul_b = $signed(coef.a2);
      end
      tbq_pkg::STEP_B0: begin
        mul_a = {x0_r[31], x0_r};
        mul_b = $signed(coef.b0);
      end
      tbq_pkg::STEP_SH: begin
        mul_a = {{9{y1_r[47]}}, y1_r[47:24]};
        mul_b = $signed(coef.scale);
      end
      tbq_pkg::STEP_SL: begin
        mul_a = {9'd0, y1_r[23:0]};
        mul_b = $signed(coef.scale);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // product post-processing: floor shifts and recombination of split products
  assign gain_sh  = prod_r[64:24];
  assign gain_ext = {{11{gain_sh[40]}}, gain_sh};
  assign b_term   = {{16{prod_r[64]}}, prod_r[64:29]};
  assign full_sum = $signed({hold_r[55], hold_r, 24'd0}) + $signed({{16{prod_r[64]}}, prod_r});
  assign l_term   = full_sum[80:29];
  assign y0_sat   = sat48(acc_r);

  // working registers, stepped by the schedule
  always_ff @(posedge clk) begin
    if (ctl.run) begin
      case (ctl.cnt)
        tbq_pkg::STEP_GAIN + 4'd1: x0_r <= sat32(gain_ext);
        tbq_pkg::STEP_B1 + 4'd1,
        tbq_pkg::STEP_B2 + 4'd1,
        tbq_pkg::STEP_B0 + 4'd1: term_r <= b_term;
        tbq_pkg::STEP_A1H + 4'd1,
        tbq_pkg::STEP_A2H + 4'd1,
        tbq_pkg::STEP_SH + 4'd1: hold_r <= prod_r[55:0];
        tbq_pkg::STEP_A1L + 4'd1,
        tbq_pkg::STEP_A2L + 4'd1,
        tbq_pkg::STEP_SL + 4'd1: term_r <= l_term;
        default: ;
      endcase
      // accumulate the five biquad terms
      case (ctl.cnt)
        tbq_pkg::STEP_B1 + 4'd2: acc_r <= {{4{term_r[51]}}, term_r};
        tbq_pkg::STEP_B2 + 4'd2,
        tbq_pkg::STEP_A1L + 4'd2,
        tbq_pkg::STEP_A2L + 4'd2,
        tbq_pkg::STEP_B0 + 4'd2: acc_r <= acc_r + {{4{term_r[51]}}, term_r};
        default: ;
      endcase
      if (ctl.cnt == tbq_pkg::STEP_LAST) begin
        res_r <= sat32(term_r);
      end
    end
  end

  // delay line update once the sum is done
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_r <= '0;
      x2_r <= '0;
      y1_r <= '0;
      y2_r <= '0;
    end else if (ctl.run && ctl.cnt == tbq_pkg::STEP_UPD) begin
      x2_r <= x1_r;
      x1_r <= x0_r;
      y2_r <= y1_r;
      y1_r <= y0_sat;
    end
  end

  assign res = res_r;

endmodule

`default_nettype wire

FILE: src/tbq_merge.sv
`timescale 1ns / 1ps
`default_nettype none

module tbq_merge #(
  parameter int NL = 3
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 load,
  input  wire signed [31:0]   lane_res [NL],
  input  wire                 out_stall,
  output logic                out_valid,
  output logic signed [31:0]  out_filt_x,
  output logic signed [31:0]  out_filt_y,
  output logic signed [31:0]  out_filt_z,
  output logic                free
);

  logic signed [31:0] axis_res [tbq_pkg::NUM_AXES];
  logic signed [31:0] filt_r   [tbq_pkg::NUM_AXES];
  logic               out_valid_r;

  // axes without a lane report zero
  for (genvar a = 0; a < tbq_pkg::NUM_AXES; a++) begin : g_axis
    if (a < NL) begin : g_lane
      assign axis_res[a] = lane_res[a];
    end else begin : g_zero
      assign axis_res[a] = '0;
    end
  end

  assign free = !out_valid_r || !out_stall;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int a = 0; a < tbq_pkg::NUM_AXES; a++) begin
        filt_r[a] <= axis_res[a];
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_filt_x = filt_r[0];
  assign out_filt_y = filt_r[1];
  assign out_filt_z = filt_r[2];

endmodule

`default_nettype wire
